### rtl/hcs_pkg.sv
// hcs_pkg: shared types, codes and helpers of the hermite curve sampler
// no dependencies; used by every module under rtl
package hcs_pkg;

    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_APPEND  = 3'd1;
    localparam logic [2:0] OP_SET_POS = 3'd2;
    localparam logic [2:0] OP_SET_RAD = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;
    localparam logic [2:0] OP_SAMPLE  = 3'd5;
    localparam logic [2:0] OP_NONE    = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int InWidth  = 336;
    localparam int OutWidth = 144;

    typedef struct packed {
        logic [2:0]         operation;
        logic [5:0]         point_index;
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] position_z;
        logic signed [31:0] tangent_in_x;
        logic signed [31:0] tangent_in_y;
        logic signed [31:0] tangent_in_z;
        logic signed [31:0] tangent_out_x;
        logic signed [31:0] tangent_out_y;
        logic signed [31:0] tangent_out_z;
        logic signed [31:0] scalar_value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_radius;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### rtl/hcs_front.sv
// hcs_front: unpacks input transactions into commands for the queue
// depends on hcs_pkg
module hcs_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hcs_pkg::InWidth-1:0]  s_tdata,
    input  hcs_pkg::queue_status_t       q_status,
    output logic                         q_push,
    output hcs_pkg::cmd_t                q_cmd
);

    logic [2:0] op;

    assign op       = s_tdata[2:0];
    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid && !q_status.full;

    always_comb begin
        q_cmd.point_index   = s_tdata[8:3];
        q_cmd.position_x    = s_tdata[40:9];
        q_cmd.position_y    = s_tdata[72:41];
        q_cmd.position_z    = s_tdata[104:73];
        q_cmd.tangent_in_x  = s_tdata[136:105];
        q_cmd.tangent_in_y  = s_tdata[168:137];
        q_cmd.tangent_in_z  = s_tdata[200:169];
        q_cmd.tangent_out_x = s_tdata[232:201];
        q_cmd.tangent_out_y = s_tdata[264:233];
        q_cmd.tangent_out_z = s_tdata[296:265];
        q_cmd.scalar_value  = s_tdata[328:297];
        // unused codes all fold into one no-op kind
        case (op)
            hcs_pkg::OP_CLEAR, hcs_pkg::OP_APPEND, hcs_pkg::OP_SET_POS,
            hcs_pkg::OP_SET_RAD, hcs_pkg::OP_READ, hcs_pkg::OP_SAMPLE: begin
                q_cmd.operation = op;
            end
            default: begin
                q_cmd.operation = hcs_pkg::OP_NONE;
            end
        endcase
    end

endmodule

### rtl/hcs_queue.sv
// hcs_queue: two-entry command queue between front and back
// depends on hcs_pkg
module hcs_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  hcs_pkg::cmd_t          push_cmd,
    input  logic                   pop,
    output hcs_pkg::queue_status_t q_status,
    output hcs_pkg::cmd_t          head
);

    hcs_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign q_status.valid = fill_reg != 2'd0;
    assign q_status.full  = fill_reg == 2'd2;
    assign head           = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

### rtl/hcs_back.sv
// hcs_back: point table, segment modulo unit and shared multiply-accumulate
// depends on hcs_pkg
module hcs_back #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   closed_loop,
    input  hcs_pkg::queue_status_t q_status,
    input  hcs_pkg::cmd_t          cmd,
    output logic                   q_pop,
    output logic                   res_valid,
    input  logic                   res_ready,
    output hcs_pkg::result_t       res,
    output logic [6:0]             count_now
);

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int IW  = (CW > 6) ? CW : 6;
    localparam int SW  = 32 - FRAC_BITS;
    localparam int MW  = (SW > CW) ? SW : CW;
    localparam int NW  = $clog2(SW + 1);
    localparam int HW  = FRAC_BITS + 3;
    localparam int PW  = HW + 32;
    localparam int RPW = 34 + FRAC_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MOD  = 4'd1;
    localparam logic [3:0] S_FIX  = 4'd2;
    localparam logic [3:0] S_RD0  = 4'd3;
    localparam logic [3:0] S_RD1  = 4'd4;
    localparam logic [3:0] S_RD2  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_RMUL = 4'd8;
    localparam logic [3:0] S_RADD = 4'd9;
    localparam logic [3:0] S_RDO  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;

    logic [95:0] pos_mem  [MAX_POINTS];
    logic [95:0] tin_mem  [MAX_POINTS];
    logic [95:0] tout_mem [MAX_POINTS];
    logic [31:0] rad_mem  [MAX_POINTS];
    logic [95:0] rd_pos_reg, rd_tin_reg, rd_tout_reg;
    logic [31:0] rd_rad_reg;

    logic [95:0] p0_reg, m0_reg;
    logic [31:0] r0_reg;

    logic [IW-1:0]        idx_w;
    logic                 idx_ok, full, go;
    logic [1:0]           status_w;
    logic [SW-1:0]        seg;
    logic [SW-1:0]        mag;
    logic [MW-1:0]        seg_w, nm2_w;
    logic [AW-1:0]        clamp_i0;
    logic                 neg_reg;
    logic [SW-1:0]        mag_reg;
    logic [NW-1:0]        bit_cnt_reg;
    logic [CW-1:0]        rem_reg;
    logic [CW:0]          rem_sh, rem_sub;
    logic [CW-1:0]        rem_new;
    logic [FRAC_BITS-1:0] u_reg, u2_reg, u3_reg;
    logic [2*FRAC_BITS-1:0] usq;
    logic [AW-1:0]        i0_reg, i1, rd_addr, wr_addr;
    logic [CW-1:0]        i0_inc;
    logic                 we_pos, we_tan, we_rad;

    logic signed [HW-1:0] h_reg [4];
    logic signed [HW-1:0] h_sel, u2_s, u3_s;
    logic signed [31:0]   v_sel;
    logic [1:0]           term_reg, k_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [63:0]   acc_reg, acc_sum, acc_shift;
    logic signed [RPW-1:0] rprod_reg;
    logic signed [32:0]   rdiff;
    logic signed [31:0]   coord_sat;

    hcs_pkg::result_t res_reg;

    assign idx_w  = IW'(cmd.point_index);
    assign idx_ok = idx_w < IW'(count_reg);
    assign full   = count_reg == CW'(MAX_POINTS);
    assign go     = state_reg == S_IDLE && q_status.valid;
    assign q_pop  = go;

    // status of the command at the queue head
    always_comb begin
        status_w = hcs_pkg::ST_OK;
        if (cmd.operation == hcs_pkg::OP_APPEND && full)
            status_w = hcs_pkg::ST_FULL;
        else if (cmd.operation inside {hcs_pkg::OP_SET_POS, hcs_pkg::OP_SET_RAD,
                                       hcs_pkg::OP_READ} && !idx_ok)
            status_w = hcs_pkg::ST_RANGE;
    end

    // segment split and open-curve clamp
    assign seg      = cmd.scalar_value[31:FRAC_BITS];
    assign mag      = seg[SW-1] ? (~seg + 1'b1) : seg;
    assign seg_w    = MW'(seg);
    assign nm2_w    = MW'(count_reg - CW'(2));
    assign clamp_i0 = seg[SW-1] ? '0 : ((seg_w > nm2_w) ? AW'(nm2_w) : AW'(seg_w));

    // restoring remainder, one bit of |segment| a cycle
    assign rem_sh  = {rem_reg, mag_reg[SW-1]};
    assign rem_sub = rem_sh - (CW+1)'(count_reg);
    assign rem_new = (rem_sh >= (CW+1)'(count_reg)) ? rem_sub[CW-1:0] : rem_sh[CW-1:0];

    assign i0_inc = CW'(i0_reg) + CW'(1);
    assign i1     = (i0_inc == count_reg) ? '0 : AW'(i0_inc);

    assign we_tan  = go && cmd.operation == hcs_pkg::OP_APPEND && !full;
    assign we_pos  = we_tan || (go && cmd.operation == hcs_pkg::OP_SET_POS && idx_ok);
    assign we_rad  = we_tan || (go && cmd.operation == hcs_pkg::OP_SET_RAD && idx_ok);
    assign wr_addr = (cmd.operation == hcs_pkg::OP_APPEND) ? AW'(count_reg) : AW'(idx_w);

    always_comb begin
        case (state_reg)
            S_IDLE: begin
                rd_addr = (cmd.operation == hcs_pkg::OP_SAMPLE) ? '0 : AW'(idx_w);
            end
            S_RD0: begin
                rd_addr = i0_reg;
            end
            default: begin
                rd_addr = i1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we_pos)
            pos_mem[wr_addr] <= {cmd.position_z, cmd.position_y, cmd.position_x};
        if (we_tan) begin
            tin_mem[wr_addr]  <= {cmd.tangent_in_z, cmd.tangent_in_y, cmd.tangent_in_x};
            tout_mem[wr_addr] <= {cmd.tangent_out_z, cmd.tangent_out_y, cmd.tangent_out_x};
        end
        if (we_rad)
            rad_mem[wr_addr] <= cmd.scalar_value;
        rd_pos_reg  <= pos_mem[rd_addr];
        rd_tin_reg  <= tin_mem[rd_addr];
        rd_tout_reg <= tout_mem[rd_addr];
        rd_rad_reg  <= rad_mem[rd_addr];
    end

    // multiply operand selection
    assign h_sel = h_reg[term_reg];
    always_comb begin
        case (term_reg)
            2'd0:    v_sel = p0_reg[32*k_reg +: 32];
            2'd1:    v_sel = m0_reg[32*k_reg +: 32];
            2'd2:    v_sel = rd_pos_reg[32*k_reg +: 32];
            default: v_sel = rd_tin_reg[32*k_reg +: 32];
        endcase
    end

    assign acc_sum   = acc_reg + 64'(prod_reg);
    assign acc_shift = acc_sum >>> FRAC_BITS;
    assign coord_sat = hcs_pkg::sat32(acc_shift);
    assign rdiff     = 33'(signed'(rd_rad_reg)) - 33'(signed'(r0_reg));
    assign usq       = (state_reg == S_RD0) ? (u_reg * u_reg) : (u2_reg * u_reg);
    assign u2_s      = HW'(signed'({1'b0, u2_reg}));
    assign u3_s      = HW'(signed'({1'b0, u3_reg}));

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            S_IDLE: begin
                if (go) begin
                    state_next = S_OUT;
                    case (cmd.operation)
                        hcs_pkg::OP_CLEAR: count_next = '0;
                        hcs_pkg::OP_APPEND: begin
                            if (!full)
                                count_next = count_reg + CW'(1);
                        end
                        hcs_pkg::OP_READ: begin
                            if (idx_ok)
                                state_next = S_RDO;
                        end
                        hcs_pkg::OP_SAMPLE: begin
                            if (count_reg == CW'(1))
                                state_next = S_RDO;
                            else if (count_reg != '0)
                                state_next = closed_loop ? S_MOD : S_RD0;
                        end
                        default: ;
                    endcase
                end
            end
            S_MOD:  state_next = (bit_cnt_reg == NW'(1)) ? S_FIX : S_MOD;
            S_FIX:  state_next = S_RD0;
            S_RD0:  state_next = S_RD1;
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_MUL;
            S_MUL:  state_next = S_ADD;
            S_ADD: begin
                if (term_reg == 2'd3 && k_reg == 2'd2)
                    state_next = S_RMUL;
                else
                    state_next = S_MUL;
            end
            S_RMUL: state_next = S_RADD;
            S_RADD: state_next = S_OUT;
            S_RDO:  state_next = S_OUT;
            S_OUT:  state_next = res_ready ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                res_reg     <= '{out_x: '0, out_y: '0, out_z: '0, out_radius: '0,
                                 status: status_w};
                neg_reg     <= seg[SW-1];
                mag_reg     <= mag;
                u_reg       <= cmd.scalar_value[FRAC_BITS-1:0];
                rem_reg     <= '0;
                bit_cnt_reg <= NW'(SW);
                i0_reg      <= clamp_i0;
                term_reg    <= 2'd0;
                k_reg       <= 2'd0;
                acc_reg     <= '0;
            end
            S_MOD: begin
                rem_reg     <= rem_new;
                mag_reg     <= mag_reg << 1;
                bit_cnt_reg <= bit_cnt_reg - NW'(1);
            end
            S_FIX: begin
                i0_reg <= (neg_reg && rem_reg != '0) ? AW'(count_reg - rem_reg) : AW'(rem_reg);
            end
            S_RD0: begin
                u2_reg <= usq[2*FRAC_BITS-1:FRAC_BITS];
            end
            S_RD1: begin
                u3_reg <= usq[2*FRAC_BITS-1:FRAC_BITS];
                p0_reg <= rd_pos_reg;
                m0_reg <= rd_tout_reg;
                r0_reg <= rd_rad_reg;
            end
            S_RD2: begin
                h_reg[0] <= (u3_s <<< 1) - (u2_s + (u2_s <<< 1)) + (HW'(1) <<< FRAC_BITS);
                h_reg[1] <= u3_s - (u2_s <<< 1) + HW'(signed'({1'b0, u_reg}));
                h_reg[2] <= (u2_s + (u2_s <<< 1)) - (u3_s <<< 1);
                h_reg[3] <= u3_s - u2_s;
            end
            S_MUL: begin
                prod_reg <= PW'(h_sel) * PW'(v_sel);
            end
            S_ADD: begin
                term_reg <= term_reg + 2'd1;
                if (term_reg == 2'd3) begin
                    acc_reg <= '0;
                    k_reg   <= k_reg + 2'd1;
                    case (k_reg)
                        2'd0:    res_reg.out_x <= coord_sat;
                        2'd1:    res_reg.out_y <= coord_sat;
                        default: res_reg.out_z <= coord_sat;
                    endcase
                end else begin
                    acc_reg <= acc_sum;
                end
            end
            S_RMUL: begin
                rprod_reg <= RPW'(rdiff) * RPW'(signed'({1'b0, u_reg}));
            end
            S_RADD: begin
                res_reg.out_radius <= hcs_pkg::sat32(64'(signed'(r0_reg)) +
                                                     (64'(rprod_reg) >>> FRAC_BITS));
            end
            S_RDO: begin
                res_reg.out_x      <= rd_pos_reg[31:0];
                res_reg.out_y      <= rd_pos_reg[63:32];
                res_reg.out_z      <= rd_pos_reg[95:64];
                res_reg.out_radius <= rd_rad_reg;
            end
            default: ;
        endcase
    end

    assign res_valid = state_reg == S_OUT;
    assign res       = res_reg;
    assign count_now = 7'(count_reg);

endmodule

### rtl/hermite_curve_sampler.sv
// hermite_curve_sampler: top level, stream ports, register port and wiring
// depends on hcs_pkg, hcs_front, hcs_queue and hcs_back
//
//  channel   direction  handshake          contents
//  s_        in         s_tvalid/s_tready  command transaction (operation, index, point data)
//  m_        out        m_tvalid/m_tready  result transaction (position, radius, status, count)
//  apb       in/out     psel/penable       closed_loop register at byte address 0
//
// from the queue head: clear, append, set, unused codes and failed reads go
// from decode to the result; reads and one-point samples load the table entry
// between the two; an open-curve sample reads its two points, builds the basis
// weights, then runs 12 position terms on the shared multiply-accumulate and
// one radius term, each a multiply step and an accumulate step; a closed one
// first runs the bit-serial segment modulo and its sign fix
// reset (aresetn low, synchronous) empties the table and queue
// the two-entry queue takes transactions until full while a result waits on m_tready
module hermite_curve_sampler #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // operation[2:0], point_index[8:3], position_x/y/z, tangent_in_x/y/z,
    // tangent_out_x/y/z, scalar_value (32 bits each from bit 9 up), zero pad
    input  logic [hcs_pkg::InWidth-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_radius[127:96],
    // status[129:128], count_now[136:130], zero pad
    output logic [hcs_pkg::OutWidth-1:0] m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic                   closed_loop_reg;
    logic                   q_push, q_pop;
    hcs_pkg::queue_status_t q_status;
    hcs_pkg::cmd_t          push_cmd, head_cmd;
    hcs_pkg::result_t       res;
    logic [6:0]             count_now;

    // register port: single register, pready tied high
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, closed_loop_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closed_loop_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            closed_loop_reg <= pwdata[0];
        end
    end

    // front end unpacks commands into the queue
    hcs_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    hcs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .q_status (q_status),
        .head     (head_cmd)
    );

    // back end owns the table and all arithmetic
    hcs_back #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .closed_loop (closed_loop_reg),
        .q_status    (q_status),
        .cmd         (head_cmd),
        .q_pop       (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res),
        .count_now   (count_now)
    );

    assign m_tdata = {7'd0, count_now, res.status, res.out_radius,
                      res.out_z, res.out_y, res.out_x};

endmodule
